// ===== hdl/mts_pkg.sv =====
// Package for the markup tag stripper: character codes and tag tracking state type.
package mts_pkg;

   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_LOWER_S = 8'h73;
   localparam logic [7:0] CH_UPPER_S = 8'h53;

   localparam logic [7:0] WORD_LOWER [4] = '{8'h6E, 8'h62, 8'h73, 8'h70};
   localparam logic [7:0] WORD_UPPER [4] = '{8'h4E, 8'h42, 8'h53, 8'h50};

   typedef struct packed {
      logic       inside_tag;
      logic       suppress_text;
      logic [7:0] recent2;
      logic [7:0] recent1;
      logic [7:0] recent0;
      logic       seen_lt_s;
      logic       seen_lt_slash;
      logic       seen_nbsp;
   } tag_state_type;

   localparam tag_state_type TAG_STATE_RESET = '0;

endpackage

// ===== hdl/markup_tag_stripper_top.sv =====
// Markup tag stripper top level: input register, tag tracking logic, result register.
//
// Channel | Direction | tdata          | tuser         | tlast
// req     | in        | [7:0] in_char  | -             | last_char
// rsp     | out       | [7:0] out_char | [0] emit_char | end_of_text
//
// One result per input transfer, passing through the input register and the
// result register. A transfer is taken every cycle while rsp_tready is high.
// The tag state updates when an item moves from the input register to the
// result register. A stall on rsp holds the result register; the input
// register still takes one transfer, then req_tready drops until rsp moves.
// Reset is synchronous and clears the tag state and both valid flags.
module markup_tag_stripper_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [0:0] rsp_tuser,   // [0] emit_char
   output logic       rsp_tlast
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_char_ff;
   logic                  in_last_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_char_ff, out_char_in;
   logic                  out_emit_ff, out_emit_in;
   logic                  out_last_ff;
   mts_pkg::tag_state_type state_ff, state_in;

   logic       advance;
   logic       take;
   logic [7:0] c;
   logic       open_now;
   logic       inside_now;
   logic       term;
   logic       lt_s_n, lt_slash_n, nbsp_n;

   assign advance    = !out_valid_ff || rsp_tready;
   assign take       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign c          = in_char_ff;
   assign open_now   = (c == mts_pkg::CH_LT) || (c == mts_pkg::CH_AMP);
   assign inside_now = state_ff.inside_tag || open_now;
   assign term       = (c == mts_pkg::CH_GT) || (c == mts_pkg::CH_SEMI);

   always_comb begin
      lt_s_n     = state_ff.seen_lt_s;
      lt_slash_n = state_ff.seen_lt_slash;
      nbsp_n     = state_ff.seen_nbsp;
      if (inside_now) begin
         if (state_ff.recent0 == mts_pkg::CH_LT &&
             (c == mts_pkg::CH_LOWER_S || c == mts_pkg::CH_UPPER_S)) begin
            lt_s_n = 1'b1;
         end
         if (state_ff.recent0 == mts_pkg::CH_LT && c == mts_pkg::CH_SLASH) begin
            lt_slash_n = 1'b1;
         end
         if ((state_ff.recent2 == mts_pkg::WORD_LOWER[0] &&
              state_ff.recent1 == mts_pkg::WORD_LOWER[1] &&
              state_ff.recent0 == mts_pkg::WORD_LOWER[2] &&
              c == mts_pkg::WORD_LOWER[3]) ||
             (state_ff.recent2 == mts_pkg::WORD_UPPER[0] &&
              state_ff.recent1 == mts_pkg::WORD_UPPER[1] &&
              state_ff.recent0 == mts_pkg::WORD_UPPER[2] &&
              c == mts_pkg::WORD_UPPER[3])) begin
            nbsp_n = 1'b1;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      out_emit_in = 1'b0;
      out_char_in = 8'h00;
      if (inside_now) begin
         state_in.inside_tag    = 1'b1;
         state_in.seen_lt_s     = lt_s_n;
         state_in.seen_lt_slash = lt_slash_n;
         state_in.seen_nbsp     = nbsp_n;
         state_in.recent2       = state_ff.recent1;
         state_in.recent1       = state_ff.recent0;
         state_in.recent0       = c;
      end
      if (term) begin
         state_in.inside_tag = 1'b0;
         if (lt_s_n) begin
            state_in.suppress_text = 1'b1;
         end
         if (lt_slash_n) begin
            state_in.suppress_text = 1'b0;
         end
         if (nbsp_n) begin
            out_emit_in = 1'b1;
            out_char_in = mts_pkg::CH_SPACE;
         end
         state_in.recent2       = 8'h00;
         state_in.recent1       = 8'h00;
         state_in.recent0       = 8'h00;
         state_in.seen_lt_s     = 1'b0;
         state_in.seen_lt_slash = 1'b0;
         state_in.seen_nbsp     = 1'b0;
      end else if (!inside_now && !state_ff.suppress_text) begin
         out_emit_in = 1'b1;
         out_char_in = c;
      end
      // last character of the text returns the tag state to reset
      if (in_last_ff) begin
         state_in = mts_pkg::TAG_STATE_RESET;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= mts_pkg::TAG_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (take) begin
         out_char_ff <= out_char_in;
         out_emit_ff <= out_emit_in;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_char_ff;
   assign rsp_tuser[0] = out_emit_ff;
   assign rsp_tlast    = out_last_ff;

endmodule
